/* rtl/core/utf8_code_point_decoder_assert.svh */
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared property forms for the decoder's port checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_CODE_POINT_DECODER_ASSERT_SVH
`define UTF8_CODE_POINT_DECODER_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define UCPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("utf8 decoder check failed");

// Next-cycle implication, checked only while out of reset.
`define UCPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("utf8 decoder check failed");

`endif

/* rtl/core/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Status codes, lane and result types, and scalar value limits.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ARG = 2'd1,
        ST_PARSE   = 2'd2
    } t_status;

    // What one byte lane reports about a trailing byte.
    typedef struct packed {
        logic       cont;
        logic [5:0] bits;
    } t_lane;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_count;
        t_status     status;
    } t_result;

    localparam logic [20:0] MAX_SCALAR    = 21'h10FFFF;
    localparam logic [15:0] SURR_FIRST    = 16'hD800;
    localparam logic [15:0] SURR_LAST     = 16'hDFFF;
    localparam logic [1:0]  CONT_TAG      = 2'b10;
    localparam int          NUM_TRAIL     = 3;

endpackage

/* rtl/core/utf8d_lane.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder byte lane
// Checks one trailing byte for the continuation tag and extracts its payload.
// ----------------------------------------------------------------------------
module utf8d_lane (
    input  logic [7:0]       i_byte,
    output utf8d_pkg::t_lane o_lane
);

    always_comb begin
        o_lane.cont = (i_byte[7:6] == utf8d_pkg::CONT_TAG);
        o_lane.bits = i_byte[5:0];
    end

endmodule

/* rtl/core/utf8d_merge.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder merge stage
// Classifies the lead byte and combines the lane reports into one result.
// ----------------------------------------------------------------------------
module utf8d_merge (
    input  logic [7:0]         i_lead,
    input  utf8d_pkg::t_lane   i_lane [utf8d_pkg::NUM_TRAIL],
    output utf8d_pkg::t_result o_result
);

    logic [10:0] cp2;
    logic [15:0] cp3;
    logic [20:0] cp4;
    logic        ok2;
    logic        ok3;
    logic        ok4;

    always_comb begin
        cp2 = {i_lead[4:0], i_lane[0].bits};
        cp3 = {i_lead[3:0], i_lane[0].bits, i_lane[1].bits};
        cp4 = {i_lead[2:0], i_lane[0].bits, i_lane[1].bits, i_lane[2].bits};

        // Overlong forms fail the lower bound of each length.
        ok2 = i_lane[0].cont && (i_lead[4:1] != 4'd0);
        ok3 = i_lane[0].cont && i_lane[1].cont && (cp3[15:11] != 5'd0)
              && !((cp3 >= utf8d_pkg::SURR_FIRST) && (cp3 <= utf8d_pkg::SURR_LAST));
        ok4 = i_lane[0].cont && i_lane[1].cont && i_lane[2].cont
              && (cp4[20:16] != 5'd0) && (cp4 <= utf8d_pkg::MAX_SCALAR);

        o_result.code_point = '0;
        o_result.byte_count = 3'd0;
        o_result.status     = utf8d_pkg::ST_PARSE;

        case (i_lead) inside
            8'h00: begin
                o_result.status = utf8d_pkg::ST_BAD_ARG;
            end
            [8'h01:8'h7F]: begin
                o_result.code_point = {13'd0, i_lead};
                o_result.byte_count = 3'd1;
                o_result.status     = utf8d_pkg::ST_OK;
            end
            [8'hC0:8'hDF]: begin
                if (ok2) begin
                    o_result.code_point = {10'd0, cp2};
                    o_result.byte_count = 3'd2;
                    o_result.status     = utf8d_pkg::ST_OK;
                end
            end
            [8'hE0:8'hEF]: begin
                if (ok3) begin
                    o_result.code_point = {5'd0, cp3};
                    o_result.byte_count = 3'd3;
                    o_result.status     = utf8d_pkg::ST_OK;
                end
            end
            [8'hF0:8'hF7]: begin
                if (ok4) begin
                    o_result.code_point = cp4;
                    o_result.byte_count = 3'd4;
                    o_result.status     = utf8d_pkg::ST_OK;
                end
            end
            default: begin
                // Stray continuation bytes and five-byte or longer leads.
                o_result.status = utf8d_pkg::ST_PARSE;
            end
        endcase
    end

endmodule

/* rtl/core/utf8_code_point_decoder.sv */
// ----------------------------------------------------------------------------
// UTF-8 code point decoder
// Decodes the character at the head of a four-byte window into its scalar
// value, byte count and status, rejecting every malformed form.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+---------------------------------------
//  input   | i_valid / o_stall       | i_lead_byte, i_second_byte,
//          |                         | i_third_byte, i_fourth_byte
//  output  | o_valid / i_stall       | o_code_point, o_byte_count, o_status
//
//  The lanes and the merge stage are combinational, so each accepted beat
//  goes straight into a register. A skid register behind the output
//  register catches one beat when the output is stalled; o_stall rises
//  only while that skid register is full, and a new beat can be taken
//  every cycle while it is empty.
//  Synchronous active-low reset empties both registers.
//
module utf8_code_point_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_lead_byte,
    input  logic [7:0]  i_second_byte,
    input  logic [7:0]  i_third_byte,
    input  logic [7:0]  i_fourth_byte,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_byte_count,
    output logic [1:0]  o_status
);

    // One lane per trailing byte; each checks its own continuation tag in
    // parallel with the others.
    utf8d_pkg::t_lane   lanes [utf8d_pkg::NUM_TRAIL];
    utf8d_pkg::t_result result;

    utf8d_lane u_lane1 (.i_byte(i_second_byte), .o_lane(lanes[0]));
    utf8d_lane u_lane2 (.i_byte(i_third_byte),  .o_lane(lanes[1]));
    utf8d_lane u_lane3 (.i_byte(i_fourth_byte), .o_lane(lanes[2]));

    // The merge stage picks the length from the lead byte and applies the
    // range, overlong and surrogate checks for that length.
    utf8d_merge u_merge (
        .i_lead   (i_lead_byte),
        .i_lane   (lanes),
        .o_result (result)
    );

    // Output register plus one-entry skid register.
    logic               r_out_valid;
    logic               n_out_valid;
    utf8d_pkg::t_result r_out;
    utf8d_pkg::t_result n_out;
    logic               r_skid_valid;
    logic               n_skid_valid;
    utf8d_pkg::t_result r_skid;
    utf8d_pkg::t_result n_skid;
    logic               accept;
    logic               out_free;

    assign accept   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                // A parked beat goes out first; no new beat is taken now.
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = accept;
                if (accept) begin
                    n_out = result;
                end
            end
        end else if (accept) begin
            // Output is held by the consumer, so park the new beat.
            n_skid       = result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_code_point = r_out.code_point;
    assign o_byte_count = r_out.byte_count;
    assign o_status     = r_out.status;

endmodule

/* rtl/core/utf8d_checker.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the decoder's ports for result consistency and beat flow.
// ----------------------------------------------------------------------------
`include "utf8_code_point_decoder_assert.svh"

module utf8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [20:0] o_code_point,
    input logic [2:0]  o_byte_count,
    input logic [1:0]  o_status
);

    logic        ok_beat;
    logic        err_beat;
    logic        in_surr;
    logic [25:0] out_word;

    assign ok_beat  = o_valid && (o_status == utf8d_pkg::ST_OK);
    assign err_beat = o_valid && (o_status != utf8d_pkg::ST_OK);
    assign in_surr  = (o_code_point >= 21'h00D800) && (o_code_point <= 21'h00DFFF);
    assign out_word = {o_code_point, o_byte_count, o_status};

    // A good result always used one to four bytes.
    `UCPD_ASSERT_NOW(a_ok_count, ok_beat, (o_byte_count != 3'd0) && (o_byte_count <= 3'd4))

    // Any error clears the value and the count.
    `UCPD_ASSERT_NOW(a_err_zero, err_beat, (o_code_point == 21'd0) && (o_byte_count == 3'd0))

    // A good value is a scalar: in range and not a surrogate.
    `UCPD_ASSERT_NOW(a_ok_scalar, ok_beat, (o_code_point <= utf8d_pkg::MAX_SCALAR) && !in_surr)

    // After an accepted beat, the output holds a valid result on the next cycle.
    `UCPD_ASSERT_NEXT(a_accept_out, i_valid && !o_stall, o_valid)

    // A stalled result holds.
    `UCPD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(out_word))

endmodule

bind utf8_code_point_decoder utf8d_checker u_utf8d_checker (.*);
